// ===== sv/mp4bs_pkg.sv =====
// ----------------------------------------------------------------------------
// mp4bs_pkg
// shared types and constants of the top-level box splitter
// ----------------------------------------------------------------------------
package mp4bs_pkg;

   localparam int unsigned HdrBytes  = 8;
   localparam int unsigned SizeBytes = 4;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        header_byte;
      logic        box_last;
      logic        header_dropped;
      logic [31:0] box_type;
   } rsp_type;

endpackage

// ===== sv/mp4bs_if.sv =====
// ----------------------------------------------------------------------------
// mp4bs_req_if / mp4bs_rsp_if
// valid/ready channels for the byte stream and the framed result beats
// ----------------------------------------------------------------------------
interface mp4bs_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface mp4bs_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        header_byte;
   logic        box_last;
   logic        header_dropped;
   logic [31:0] box_type;

   modport source (output valid, output out_byte, output header_byte, output box_last,
                   output header_dropped, output box_type, input ready);
   modport sink   (input valid, input out_byte, input header_byte, input box_last,
                   input header_dropped, input box_type, output ready);
endinterface

// ===== sv/mp4_top_level_box_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// mp4_top_level_box_splitter_unit
// recovers top-level box framing from an mp4 byte stream
// ----------------------------------------------------------------------------
// usage:
//   req_bus carries one stream byte per beat; rsp_bus returns one beat per
//   byte with the byte itself, a header flag, an end-of-box flag, a flag for
//   a header of size at most 8 (dropped, its bytes fold into the next box)
//   and the type of the latest header.
//   path: a byte taken passes the input register, then framing logic into
//   the result register, before it shows on rsp_bus.
//   throughput: one byte per cycle unless stalled, set by the single framing
//   state update; the input register takes one more byte while a result waits.
//   stall: when rsp_bus.ready is low the result register holds, then the
//   input register fills and req_bus.ready drops.
//   reset: synchronous; both stages empty, framing restarts at a header
//   with count, size and type cleared.
// ----------------------------------------------------------------------------
module mp4_top_level_box_splitter_unit (
   input  logic         clock,
   input  logic         reset,
   mp4bs_req_if.sink    req_bus,
   mp4bs_rsp_if.source  rsp_bus
);

   logic               in_valid_ff;
   logic [7:0]         in_byte_ff;
   logic               out_valid_ff;
   mp4bs_pkg::rsp_type out_ff;
   mp4bs_pkg::rsp_type out_in;
   logic               advance;
   logic               step;

   assign advance       = !out_valid_ff || rsp_bus.ready;
   assign step          = in_valid_ff && advance;
   assign req_bus.ready = !in_valid_ff || advance;

   mp4bs_framer u_framer (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .data_in (in_byte_ff),
      .result  (out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_bus.ready) begin
            in_valid_ff <= req_bus.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
      if (req_bus.ready && req_bus.valid) begin
         in_byte_ff <= req_bus.in_byte;
      end
      if (step) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.out_byte       = out_ff.out_byte;
   assign rsp_bus.header_byte    = out_ff.header_byte;
   assign rsp_bus.box_last       = out_ff.box_last;
   assign rsp_bus.header_dropped = out_ff.header_dropped;
   assign rsp_bus.box_type       = out_ff.box_type;

endmodule

// ===== sv/mp4bs_framer.sv =====
// ----------------------------------------------------------------------------
// mp4bs_framer
// header/body framing state and the result of one byte
// ----------------------------------------------------------------------------
module mp4bs_framer (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_in,
   output mp4bs_pkg::rsp_type result
);

   logic        hdr_mode_ff, hdr_mode_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] left_ff, left_in;
   logic [31:0] type_ff, type_in;

   always_comb begin
      hdr_mode_in           = hdr_mode_ff;
      hdr_cnt_in            = hdr_cnt_ff;
      left_in               = left_ff;
      type_in               = type_ff;
      result.out_byte       = data_in;
      result.header_byte    = 1'b0;
      result.box_last       = 1'b0;
      result.header_dropped = 1'b0;
      if (hdr_mode_ff) begin
         result.header_byte = 1'b1;
         if (hdr_cnt_ff < 3'(mp4bs_pkg::SizeBytes)) begin
            left_in = {left_ff[23:0], data_in};
         end else begin
            type_in = {type_ff[23:0], data_in};
         end
         if (hdr_cnt_ff == 3'(mp4bs_pkg::HdrBytes - 1)) begin
            hdr_cnt_in = '0;
            if (left_ff > 32'(mp4bs_pkg::HdrBytes)) begin
               left_in     = left_ff - 32'(mp4bs_pkg::HdrBytes);
               hdr_mode_in = 1'b0;
            end else begin
               left_in               = '0;
               result.header_dropped = 1'b1;
            end
         end else begin
            hdr_cnt_in = hdr_cnt_ff + 3'd1;
         end
      end else begin
         left_in = left_ff - 32'd1;
         if (left_ff == 32'd1) begin
            result.box_last = 1'b1;
            hdr_mode_in     = 1'b1;
         end
      end
      result.box_type = type_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_mode_ff <= 1'b1;
         hdr_cnt_ff  <= '0;
         left_ff     <= '0;
         type_ff     <= '0;
      end else if (step) begin
         hdr_mode_ff <= hdr_mode_in;
         hdr_cnt_ff  <= hdr_cnt_in;
         left_ff     <= left_in;
         type_ff     <= type_in;
      end
   end

endmodule

// ===== sv/mp4bs_checker.sv =====
// ----------------------------------------------------------------------------
// mp4bs_checker
// port-level checks of the box splitter, bound to the top level
// ----------------------------------------------------------------------------
module mp4bs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_header_byte,
   input logic        rsp_box_last,
   input logic        rsp_header_dropped,
   input logic [31:0] rsp_box_type
);

   logic after_last_ff;
   logic beat;

   assign beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         after_last_ff <= 1'b0;
      end else if (beat) begin
         after_last_ff <= rsp_box_last;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_header_byte) && $stable(rsp_box_last)
         && $stable(rsp_header_dropped) && $stable(rsp_box_type))
      else $error("stalled result changed");

   a_header_after_last: assert property (@(posedge clock) disable iff (reset)
      beat && after_last_ff |-> rsp_header_byte)
      else $error("byte after end of box is not a header byte");

   a_dropped_in_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_dropped |-> rsp_header_byte && !rsp_box_last)
      else $error("dropped header flag outside a header byte");

endmodule

bind mp4_top_level_box_splitter_unit mp4bs_checker u_mp4bs_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_out_byte       (rsp_bus.out_byte),
   .rsp_header_byte    (rsp_bus.header_byte),
   .rsp_box_last       (rsp_bus.box_last),
   .rsp_header_dropped (rsp_bus.header_dropped),
   .rsp_box_type       (rsp_bus.box_type)
);

// ===== verif/mp4bs_frame_checker.sv =====
// ----------------------------------------------------------------------------
// mp4bs_frame_checker
// watches both channels of the box splitter, tracks the box framing of every
// byte taken in and compares each result beat, field by field, in order
// ----------------------------------------------------------------------------
module mp4bs_frame_checker (
   input  logic  clock,
   input  logic  reset,
   mp4bs_req_if  req_mon,
   mp4bs_rsp_if  rsp_mon,
   output int    errors,
   output int    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   logic               hdr_mode;
   logic [2:0]         hdr_count;
   logic [31:0]        size_left;
   logic [31:0]        type_word;
   mp4bs_pkg::rsp_type frame_due [$];

   initial errors = 0;

   task automatic report(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      errors++;
   endtask

   task automatic frame_byte(input logic [7:0] b);
      mp4bs_pkg::rsp_type beat;
      beat = '0;
      beat.out_byte = b;
      if (hdr_mode) begin
         beat.header_byte = 1'b1;
         if (hdr_count < mp4bs_pkg::SizeBytes) size_left = {size_left[23:0], b};
         else type_word = {type_word[23:0], b};
         if (hdr_count == mp4bs_pkg::HdrBytes - 1) begin
            if (size_left > mp4bs_pkg::HdrBytes) begin
               size_left = size_left - 32'(mp4bs_pkg::HdrBytes);
               hdr_mode  = 1'b0;
            end else begin
               // header too small to hold a box: its bytes fold into the next one
               size_left          = '0;
               beat.header_dropped = 1'b1;
            end
            hdr_count = '0;
         end else begin
            hdr_count = hdr_count + 3'd1;
         end
      end else begin
         size_left = size_left - 32'd1;
         if (size_left == 0) begin
            beat.box_last = 1'b1;
            hdr_mode      = 1'b1;
         end
      end
      beat.box_type = type_word;
      frame_due = {frame_due, beat};
   endtask

   always @(posedge clock) begin
      mp4bs_pkg::rsp_type want;
      if (reset) begin
         hdr_mode  = 1'b1;
         hdr_count = '0;
         size_left = '0;
         type_word = '0;
         frame_due.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) frame_byte(req_mon.in_byte);
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (frame_due.size() == 0) begin
               report($sformatf("beat %h with nothing due", rsp_mon.out_byte));
            end else begin
               want = frame_due.pop_front();
               if (rsp_mon.out_byte !== want.out_byte)
                  report($sformatf("out_byte got %h want %h",
                                   rsp_mon.out_byte, want.out_byte));
               if (rsp_mon.header_byte !== want.header_byte)
                  report($sformatf("header_byte got %b want %b",
                                   rsp_mon.header_byte, want.header_byte));
               if (rsp_mon.box_last !== want.box_last)
                  report($sformatf("box_last got %b want %b",
                                   rsp_mon.box_last, want.box_last));
               if (rsp_mon.header_dropped !== want.header_dropped)
                  report($sformatf("header_dropped got %b want %b",
                                   rsp_mon.header_dropped, want.header_dropped));
               if (rsp_mon.box_type !== want.box_type)
                  report($sformatf("box_type got %h want %h",
                                   rsp_mon.box_type, want.box_type));
            end
         end
      end
      pending = frame_due.size();
   end

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// drives mp4 box streams into the top-level box splitter: a few hand-made
// boxes at the size limits, then random boxes and undersized headers under
// changing sender gaps and receiver stalls, ending with raw noise
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   gap_pct;
   int   stall_pct;
   int   bytes_sent;
   int   errors;
   int   pending;

   mp4bs_req_if req_bus ();
   mp4bs_rsp_if rsp_bus ();

   mp4_top_level_box_splitter_unit DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   mp4bs_frame_checker frame_chk (
      .clock   (clock),
      .reset   (reset),
      .req_mon (req_bus),
      .rsp_mon (rsp_bus),
      .errors  (errors),
      .pending (pending)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      rsp_bus.ready <= reset ? 1'b0 : ($urandom_range(99) >= stall_pct);
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < gap_pct) begin
         req_bus.valid   <= 1'b0;
         req_bus.in_byte <= 8'($urandom_range(255));
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.in_byte <= b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) send_byte(w[31 - 8*i -: 8]);
   endtask

   task automatic send_box(input logic [31:0] size, input logic [31:0] four_cc,
                           input int unsigned body_len);
      send_word(size);
      send_word(four_cc);
      repeat (body_len) send_byte(8'($urandom_range(255)));
   endtask

   initial begin
      int unsigned body;
      int unsigned pick;
      logic [31:0] four_cc;
      req_bus.valid   = 1'b0;
      req_bus.in_byte = '0;
      gap_pct    = 0;
      stall_pct  = 0;
      bytes_sent = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // one-byte body, all-ones type and data
      send_word(32'd9);
      send_word(32'hFFFF_FFFF);
      send_byte(8'hFF);
      // size 8 and size 0 headers are dropped
      send_box(32'd8, 32'h0000_0000, 0);
      send_box(32'd0, 32'h6D64_6174, 0);

      while (bytes_sent < 525) begin
         if (bytes_sent < 150) begin
            gap_pct = 0;  stall_pct = 0;
         end else if (bytes_sent < 275) begin
            gap_pct = 58; stall_pct = 0;
         end else if (bytes_sent < 400) begin
            gap_pct = 0;  stall_pct = 58;
         end else begin
            gap_pct = 20; stall_pct = 20;
         end
         if ($urandom_range(3) == 0) begin
            four_cc = $urandom;
         end else begin
            for (int i = 0; i < 4; i++) four_cc[8*i +: 8] = 8'(8'h61 + $urandom_range(25));
         end
         pick = $urandom_range(99);
         if (pick < 80) begin
            body = ($urandom_range(15) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
            send_box(body + 8, four_cc, body);
         end else begin
            send_box($urandom_range(8), four_cc, 0);
         end
      end

      // raw noise: random size bytes reach the upper bits of the counter
      repeat (12) send_byte(8'($urandom_range(255)));
      req_bus.valid <= 1'b0;
      stall_pct = 0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
